[src/psq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psq_pkg
// Shared types, constants and a helper function for the pitch scale quantizer.
// ----------------------------------------------------------------------------
package psq_pkg;

  // Fixed field widths
  localparam int PITCH_W       = 21;
  localparam int NOTE_BITS     = 16;
  localparam int NOTE_SLOTS    = 12;
  localparam int SLOT_IDX_W    = 4;
  localparam int NOTE_CNT_W    = 4;
  localparam int CHROMA_STEPS  = 12;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;

  // Defaults for top level parameters
  localparam int DEF_MAX_NOTES = 12;
  localparam int DEF_FRAC_BITS = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_MODE = 3'd0,
    CFG_NOTE_COUNT = 3'd1,
    CFG_TUNE_LOW   = 3'd2,
    CFG_TUNE_MID   = 3'd3,
    CFG_TUNE_HIGH  = 3'd4
  } cfg_idx_t;

  // Scale selection
  typedef enum logic {
    MODE_CHROMATIC = 1'b0,
    MODE_USER      = 1'b1
  } scale_mode_t;

  // Configuration state handed from the register file to the datapath
  typedef struct packed {
    scale_mode_t                                scale_mode;
    logic [NOTE_CNT_W-1:0]                      note_count;
    logic [NOTE_SLOTS-1:0][NOTE_BITS-1:0]       tuning;
  } cfg_t;

  // Equal-tempered note k of twelve, rounded half up on the fraction grid
  function automatic int chroma_note(input int k, input int frac_bits);
    return (k * (1 << frac_bits) + 6) / 12;
  endfunction

endpackage

[src/psq_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psq_cfg
// Configuration register file: scale mode, note count and user tuning words.
// ----------------------------------------------------------------------------
module psq_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [psq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [psq_pkg::CFG_DATA_W-1:0]       cfg_data,
  output psq_pkg::cfg_t                        cfg
);

  localparam int WORD_NOTES = psq_pkg::CFG_DATA_W / psq_pkg::NOTE_BITS;

  psq_pkg::cfg_t cfg_r;
  psq_pkg::cfg_t cfg_nxt;

  // Registers take a write in every cycle
  assign cfg_ready = 1'b1;

  // Decode the write transaction
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        psq_pkg::CFG_SCALE_MODE: begin
          cfg_nxt.scale_mode = psq_pkg::scale_mode_t'(cfg_data[0]);
        end
        psq_pkg::CFG_NOTE_COUNT: begin
          cfg_nxt.note_count = cfg_data[psq_pkg::NOTE_CNT_W-1:0];
        end
        psq_pkg::CFG_TUNE_LOW: begin
          cfg_nxt.tuning[WORD_NOTES-1:0] = cfg_data;
        end
        psq_pkg::CFG_TUNE_MID: begin
          cfg_nxt.tuning[2*WORD_NOTES-1:WORD_NOTES] = cfg_data;
        end
        psq_pkg::CFG_TUNE_HIGH: begin
          cfg_nxt.tuning[3*WORD_NOTES-1:2*WORD_NOTES] = cfg_data;
        end
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // Hold configuration, clear to defaults on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_mode <= psq_pkg::MODE_CHROMATIC;
      cfg_r.note_count <= psq_pkg::NOTE_CNT_W'(1);
      cfg_r.tuning     <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[src/psq_chroma.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psq_chroma
// Snaps an octave fraction to the nearest of twelve equal-tempered notes.
// ----------------------------------------------------------------------------
module psq_chroma #(
  parameter int FRAC_BITS = psq_pkg::DEF_FRAC_BITS
) (
  input  logic        [FRAC_BITS-1:0] frac,
  output logic signed [FRAC_BITS+1:0] note
);

  localparam int PROD_W = FRAC_BITS + 5;
  localparam int TW     = FRAC_BITS + 2;
  localparam int STEPS  = psq_pkg::CHROMA_STEPS;

  logic [PROD_W-1:0]   frac_x24;
  logic [STEPS-1:0]    below;
  logic signed [TW-1:0] note_tab [STEPS+1];

  // Scale the fraction by 24 with two shifts
  assign frac_x24 = (PROD_W'(frac) << 4) + (PROD_W'(frac) << 3);

  // Compare against each midpoint between neighboring notes
  for (genvar k = 0; k < STEPS; k++) begin : g_mid
    localparam logic [PROD_W-1:0] MID = PROD_W'(2 * k + 1) << FRAC_BITS;
    assign below[k] = frac_x24 < MID;
  end

  // Note values on the fraction grid
  for (genvar k = 0; k <= STEPS; k++) begin : g_note
    assign note_tab[k] = TW'(psq_pkg::chroma_note(k, FRAC_BITS));
  end

  // Take the lowest note whose upper midpoint lies above the fraction
  always_comb begin
    note = note_tab[STEPS];
    for (int k = STEPS - 1; k >= 0; k--) begin
      if (below[k]) begin
        note = note_tab[k];
      end
    end
  end

endmodule

[src/psq_user.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psq_user
// Snaps an octave fraction to the nearest note of a user tuning, with the
// last note one octave down and the first note one octave up as guards.
// ----------------------------------------------------------------------------
module psq_user #(
  parameter int MAX_NOTES = psq_pkg::DEF_MAX_NOTES,
  parameter int FRAC_BITS = psq_pkg::DEF_FRAC_BITS
) (
  input  logic        [FRAC_BITS-1:0]                                      frac,
  input  logic        [psq_pkg::NOTE_CNT_W-1:0]                            note_count,
  input  logic        [psq_pkg::NOTE_SLOTS-1:0][psq_pkg::NOTE_BITS-1:0]    tuning,
  output logic signed [FRAC_BITS+1:0]                                      note
);

  localparam int SLOTS = psq_pkg::NOTE_SLOTS;
  localparam int NB    = psq_pkg::NOTE_BITS;
  localparam int CW    = psq_pkg::NOTE_CNT_W;
  localparam int LIM   = (MAX_NOTES < SLOTS) ? MAX_NOTES : SLOTS;
  localparam int TW    = FRAC_BITS + 2;
  localparam int SW    = FRAC_BITS + 3;
  localparam logic signed [TW-1:0] ONE_T = TW'(1) << FRAC_BITS;

  logic [FRAC_BITS-1:0]               scaled [SLOTS];
  logic [CW-1:0]                      n;
  logic [psq_pkg::SLOT_IDX_W-1:0]     last_idx;
  logic signed [TW-1:0]               first_up;
  logic signed [TW-1:0]               last_dn;
  logic signed [TW-1:0]               t_arr [LIM+2];
  logic signed [SW-1:0]               twice_f;
  logic [LIM:0]                       hit;

  // Rescale each 16-bit note to the fraction grid (truncate when narrower)
  for (genvar j = 0; j < SLOTS; j++) begin : g_scale
    logic [NB+FRAC_BITS-1:0] wide;
    assign wide      = {tuning[j], {FRAC_BITS{1'b0}}};
    assign scaled[j] = wide[NB+FRAC_BITS-1:NB];
  end

  // Clamp the note count to one through the lane limit
  always_comb begin
    priority if (note_count == '0) begin
      n = CW'(1);
    end else if (note_count > CW'(LIM)) begin
      n = CW'(LIM);
    end else begin
      n = note_count;
    end
  end

  assign last_idx = psq_pkg::SLOT_IDX_W'(n - CW'(1));
  assign first_up = TW'(scaled[0]) + ONE_T;
  assign last_dn  = TW'(scaled[last_idx]) - ONE_T;
  assign twice_f  = SW'({frac, 1'b0});

  // Build the guarded note list; entries past the count are never selected
  always_comb begin
    t_arr[0] = last_dn;
    for (int j = 1; j <= LIM; j++) begin
      if (CW'(j) <= n) begin
        t_arr[j] = TW'(scaled[j-1]);
      end else begin
        t_arr[j] = first_up;
      end
    end
    t_arr[LIM+1] = first_up;
  end

  // Compare twice the fraction against each midpoint sum
  always_comb begin
    for (int i = 0; i <= LIM; i++) begin
      hit[i] = (CW'(i) <= n) && (twice_f < (SW'(t_arr[i]) + SW'(t_arr[i+1])));
    end
  end

  // Take the first lane whose midpoint lies above the fraction
  always_comb begin
    note = first_up;
    for (int i = LIM; i >= 0; i--) begin
      if (hit[i]) begin
        note = t_arr[i];
      end
    end
  end

endmodule

[src/pitch_scale_quantizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitch_scale_quantizer
// Quantizes a 1 V/octave pitch to the nearest note of a chromatic or user
// scale, keeping the floored octave and saturating to the pitch range.
//
//   channel   ports                                  transaction
//   input     start, busy, in_pitch_in               start high, busy low
//   result    out_valid, out_pitch_out               out_valid high, 1 cycle
//   config    cfg_valid, cfg_ready, cfg_index,       cfg_valid and cfg_ready
//             cfg_data
//
// One item per clock; busy stays low. A result strobes out_valid through
// the input register and the result register around the single pass of
// note compares and the octave add.
// Reset (rst_n low at a clock edge) drops items in flight and restores the
// chromatic scale with one user note and zero tuning words.
// The receiver cannot stall; results leave on their strobe cycle.
// ----------------------------------------------------------------------------
module pitch_scale_quantizer #(
  parameter int MAX_NOTES = psq_pkg::DEF_MAX_NOTES,
  parameter int FRAC_BITS = psq_pkg::DEF_FRAC_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [psq_pkg::PITCH_W-1:0]    in_pitch_in,
  output logic                                  out_valid,
  output logic signed [psq_pkg::PITCH_W-1:0]    out_pitch_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [psq_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [psq_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int PW    = psq_pkg::PITCH_W;
  localparam int TW    = FRAC_BITS + 2;
  localparam int EXT_W = ((PW > FRAC_BITS + 1) ? PW : FRAC_BITS + 1) + 2;
  localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'((1 << (PW - 1)) - 1);
  localparam logic signed [EXT_W-1:0] SAT_LO = ~SAT_HI;

  psq_pkg::cfg_t          cfg;
  logic                   valid_r;
  logic signed [PW-1:0]   pitch_r;
  logic signed [EXT_W-1:0] pitch_ext;
  logic [FRAC_BITS-1:0]   frac;
  logic signed [EXT_W-1:0] octave_base;
  logic signed [TW-1:0]   chroma_note;
  logic signed [TW-1:0]   user_note;
  logic signed [TW-1:0]   note_sel;
  logic signed [EXT_W-1:0] sum;
  logic signed [PW-1:0]   pitch_nxt;
  logic                   out_valid_r;
  logic signed [PW-1:0]   out_pitch_r;

  assign busy = 1'b0;

  // Configuration registers
  psq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    pitch_r <= in_pitch_in;
  end

  // Split into floored octave and fraction
  assign pitch_ext   = EXT_W'(pitch_r);
  assign frac        = pitch_ext[FRAC_BITS-1:0];
  assign octave_base = {pitch_ext[EXT_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}};

  psq_chroma #(
    .FRAC_BITS (FRAC_BITS)
  ) u_chroma (
    .frac (frac),
    .note (chroma_note)
  );

  psq_user #(
    .MAX_NOTES (MAX_NOTES),
    .FRAC_BITS (FRAC_BITS)
  ) u_user (
    .frac       (frac),
    .note_count (cfg.note_count),
    .tuning     (cfg.tuning),
    .note       (user_note)
  );

  // Pick the scale, add the octave and saturate
  always_comb begin
    note_sel = (cfg.scale_mode == psq_pkg::MODE_USER) ? user_note : chroma_note;
    sum      = octave_base + EXT_W'(note_sel);
    priority if (sum > SAT_HI) begin
      pitch_nxt = PW'(SAT_HI);
    end else if (sum < SAT_LO) begin
      pitch_nxt = PW'(SAT_LO);
    end else begin
      pitch_nxt = PW'(sum);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_pitch_r <= pitch_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_pitch_out = out_pitch_r;

endmodule

[src/psq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psq_checker
// Port-level checks of result timing and quantization distance.
// ----------------------------------------------------------------------------
module psq_checker #(
  parameter int FRAC_BITS = psq_pkg::DEF_FRAC_BITS
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic signed [psq_pkg::PITCH_W-1:0]  in_pitch_in,
  input logic                                out_valid,
  input logic signed [psq_pkg::PITCH_W-1:0]  out_pitch_out
);

  localparam int PW = psq_pkg::PITCH_W;
  localparam int DW = ((PW > FRAC_BITS + 2) ? PW : FRAC_BITS + 2) + 2;
  localparam logic signed [DW-1:0] SPAN = DW'(1) << (FRAC_BITS + 1);

  // Every input transaction yields a result, delayed by the input and result registers
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("input transaction without result");

  // No result appears without an earlier input transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without input transaction");

  // A quantized pitch stays within two octaves of its input
  a_near_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((DW'(out_pitch_out) - DW'($past(in_pitch_in, 2))) < SPAN) &&
      ((DW'(out_pitch_out) - DW'($past(in_pitch_in, 2))) > -SPAN))
    else $error("quantized pitch too far from input");

endmodule

bind pitch_scale_quantizer psq_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_psq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_pitch_in   (in_pitch_in),
  .out_valid     (out_valid),
  .out_pitch_out (out_pitch_out)
);
